// ===== rtl/spd_pkg.sv =====
package spd_pkg;

    localparam int unsigned CordicGain = 652032874;
    localparam int unsigned AtanEntries = 24;
    localparam logic signed [33:0] Q30One = 34'sd1073741824;

    function automatic logic signed [33:0] atan_entry(input int unsigned idx);
        logic signed [33:0] v;
        case (idx)
            0: v = 34'sd536870912;
            1: v = 34'sd316933406;
            2: v = 34'sd167458907;
            3: v = 34'sd85004756;
            4: v = 34'sd42667331;
            5: v = 34'sd21354465;
            6: v = 34'sd10679838;
            7: v = 34'sd5340245;
            8: v = 34'sd2670163;
            9: v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/spd_if.sv =====
interface spd_in_if #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_a;
    logic [ANGLE_BITS-1:0] elevation_a;
    logic [ANGLE_BITS-1:0] azimuth_a;
    logic [RANGE_BITS-1:0] range_b;
    logic [ANGLE_BITS-1:0] elevation_b;
    logic [ANGLE_BITS-1:0] azimuth_b;

    modport source (output valid, range_a, elevation_a, azimuth_a,
                    range_b, elevation_b, azimuth_b, input ready);
    modport sink (input valid, range_a, elevation_a, azimuth_a,
                  range_b, elevation_b, azimuth_b, output ready);
endinterface

interface spd_out_if #(
    parameter int RANGE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS+2:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

// ===== rtl/spd_cordic.sv =====
module spd_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [33:0]    o_sin,
    output logic signed [33:0]    o_cos
);

    localparam int Iters = (TRIG_ITERATIONS < spd_pkg::AtanEntries) ?
                           TRIG_ITERATIONS : spd_pkg::AtanEntries;

    logic signed [33:0] r_x [Iters+1];
    logic signed [33:0] r_y [Iters+1];
    logic signed [33:0] r_z [Iters+1];
    logic [1:0]         r_q [Iters+1];
    logic [31:0]        full;

    assign full = {i_angle, {(32-ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= 34'(spd_pkg::CordicGain);
            r_y[0] <= '0;
            r_z[0] <= {4'b0, full[29:0]};
            r_q[0] <= full[31:30];
        end
    end

    for (genvar k = 0; k < Iters; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= r_q[k];
                if (!r_z[k][33]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - spd_pkg::atan_entry(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + spd_pkg::atan_entry(k);
                end
            end
        end
    end

    always_comb begin
        case (r_q[Iters])
            2'd0: begin o_cos = r_x[Iters];  o_sin = r_y[Iters];  end
            2'd1: begin o_cos = -r_y[Iters]; o_sin = r_x[Iters];  end
            2'd2: begin o_cos = -r_x[Iters]; o_sin = -r_y[Iters]; end
            default: begin o_cos = r_y[Iters]; o_sin = -r_x[Iters]; end
        endcase
    end

endmodule

// ===== rtl/spd_sqrt.sv =====
module spd_sqrt #(
    parameter int RANGE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*RANGE_BITS+6:0] i_rad,
    output logic [RANGE_BITS+2:0]   o_root
);

    localparam int Rb = RANGE_BITS + 3;
    localparam int Nb = 2 * RANGE_BITS + 7;

    logic [Nb-1:0] r_n [Rb+1];
    logic [Rb-1:0] r_r [Rb+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_rad;
            r_r[0] <= '0;
        end
    end

    for (genvar k = 0; k < Rb; k++) begin : g_bit
        localparam int B = Rb - 1 - k;
        logic [Rb-1:0]   cand;
        logic [2*Rb-1:0] sq;
        assign cand = r_r[k] | (Rb'(1) << B);
        assign sq = cand * cand;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1] <= r_n[k];
                r_r[k+1] <= (r_n[k] >= Nb'(sq)) ? cand : r_r[k];
            end
        end
    end

    assign o_root = r_r[Rb];

endmodule

// ===== rtl/spherical_point_distance.sv =====
// Streaming distance between two points in spherical form. One pair is taken
// per clock cycle while the skid register is empty; each result passes through
// the CORDIC stage chain, the product stages and the one-bit-per-stage
// square-root chain. The whole pipeline stalls together while the one-entry
// skid register holds a result that the output has not taken; that register
// keeps ready independent of the output ready.
module spherical_point_distance #(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spd_in_if.sink    i_in,
    spd_out_if.source o_out
);

    localparam int Iters = (TRIG_ITERATIONS < spd_pkg::AtanEntries) ?
                           TRIG_ITERATIONS : spd_pkg::AtanEntries;
    localparam int Lat = Iters + RANGE_BITS + 11;
    localparam int Rw = RANGE_BITS;
    localparam int Nb = 2 * RANGE_BITS + 7;

    logic en;
    logic [Lat-1:0] r_vld;
    logic r_skid_vld;
    logic [Rw+2:0] r_skid;
    logic [Rw+2:0] root;

    assign en = !r_skid_vld;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], i_in.valid};
        end
    end

    logic signed [33:0] sea, cea, seb, ceb, sd, cd;
    logic [ANGLE_BITS-1:0] da;
    assign da = i_in.azimuth_a - i_in.azimuth_b;

    spd_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_ca (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.elevation_a), .o_sin(sea), .o_cos(cea));
    spd_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cb (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.elevation_b), .o_sin(seb), .o_cos(ceb));
    spd_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cd (
        .i_clk(i_clk), .i_en(en), .i_angle(da), .o_sin(sd), .o_cos(cd));

    logic [Rw-1:0] r_ra [Iters+1];
    logic [Rw-1:0] r_rb [Iters+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra[0] <= i_in.range_a;
            r_rb[0] <= i_in.range_b;
            for (int k = 0; k < Iters; k++) begin
                r_ra[k+1] <= r_ra[k];
                r_rb[k+1] <= r_rb[k];
            end
        end
    end

    logic [Rw-1:0] ra, rb;
    assign ra = r_ra[Iters];
    assign rb = r_rb[Iters];

    logic signed [67:0] p_ss, p_cc;
    assign p_ss = sea * seb;
    assign p_cc = cea * ceb;

    logic signed [33:0] r1_ss, r1_cc, r1_cd;
    logic [Rw-1:0] r1_ra, r1_rb, r2_ra, r2_rb, r3_ra, r3_rb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ss <= 34'(p_ss >>> 30);
            r1_cc <= 34'(p_cc >>> 30);
            r1_cd <= cd;
            r1_ra <= ra;
            r1_rb <= rb;
        end
    end

    logic signed [67:0] p_g;
    assign p_g = r1_ss * r1_cd;

    logic signed [33:0] r2_g;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_g <= 34'(p_g >>> 30) + r1_cc;
            r2_ra <= r1_ra;
            r2_rb <= r1_rb;
        end
    end

    logic signed [33:0] h_s;
    logic [31:0] r3_h;
    assign h_s = spd_pkg::Q30One - r2_g;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_h <= h_s[33] ? '0 : h_s[31:0];
            r3_ra <= r2_ra;
            r3_rb <= r2_rb;
        end
    end

    logic [Rw+31:0] r4_rah;
    logic [Rw-1:0] r4_rb, r4_d;
    logic [Rw-1:0] d3;
    assign d3 = (r3_ra >= r3_rb) ? r3_ra - r3_rb : r3_rb - r3_ra;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_rah <= r3_ra * r3_h;
            r4_rb <= r3_rb;
            r4_d <= d3;
        end
    end

    logic [2*Rw+31:0] r5_t;
    logic [2*Rw-1:0]  r5_sq;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_t <= r4_rah * r4_rb;
            r5_sq <= r4_d * r4_d;
        end
    end

    logic [Nb-1:0] r6_n;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_n <= Nb'({r5_sq, 4'b0}) + Nb'(r5_t >> 25);
        end
    end

    spd_sqrt #(.RANGE_BITS(RANGE_BITS)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_rad(r6_n), .o_root(root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            r_skid_vld <= r_vld[Lat-1] && !o_out.ready;
        end else if (o_out.ready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= root;
        end
    end

    assign o_out.valid = r_skid_vld || r_vld[Lat-1];
    assign o_out.distance = r_skid_vld ? r_skid : root;

endmodule

// ===== rtl/spd_checker.sv =====
module spd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready) else $error("not ready after reset");

    a_no_out_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid) else $error("output after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("output dropped");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid) else $error("stalled without output");

endmodule

bind spherical_point_distance spd_checker u_spd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);
